>>> design/spath_pkg.sv
// shared types and constants of the all-pairs shortest path block
// no dependencies
`default_nettype none

package spath_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned WEIGHT_BITS_DEF  = 32;
  localparam int unsigned VCOUNT_W         = 7;
  localparam int unsigned VERTEX_W         = 8;
  localparam int unsigned FIELD_W          = 32;
  // wide enough for an 8-bit vertex number and for any vertex count
  localparam int unsigned CMP_W            = 9;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = VCOUNT_W'(64);

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_RECOMP = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [VERTEX_W-1:0]        vertex_a;
    logic [VERTEX_W-1:0]        vertex_b;
    logic signed [FIELD_W-1:0]  edge_weight;
    logic                       edge_present;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  distance;
    logic                       reachable;
    logic                       in_range;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/all_pairs_shortest_path.sv
// all-pairs shortest path engine: edge and distance memories with a floyd-warshall sequencer
// depends on spath_pkg
`default_nettype none

// After reset a clearing pass writes every entry of both memories, one per cycle,
// with in_ready_o low. One transaction is worked at a time. In a recompute over n
// active vertices the relaxation loop spends one state reading two distance
// entries on the two read ports and one state adding, comparing and writing back.
// A result waits in the output register while the next transaction is taken.
// Queries return the distances of the last recompute.
module all_pairs_shortest_path
  import spath_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [VCOUNT_W-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_data_o
);

  localparam int unsigned VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned AW    = 2 * VW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned WB    = WEIGHT_BITS;
  localparam int unsigned XW    = (WB > FIELD_W) ? WB : FIELD_W;

  localparam logic signed [XW-1:0] WMAX_X = XW'($signed({1'b0, {(WB-1){1'b1}}}));
  localparam logic signed [XW-1:0] WMIN_X = XW'($signed({1'b1, {(WB-1){1'b0}}}));
  localparam logic signed [XW-1:0] OMAX_X = XW'($signed({1'b0, {(FIELD_W-1){1'b1}}}));
  localparam logic signed [XW-1:0] OMIN_X = XW'($signed({1'b1, {(FIELD_W-1){1'b0}}}));

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_CP_RD, ST_CP_WR, ST_FW_IK, ST_FW_IKW,
    ST_FW_RD, ST_FW_WR, ST_QUERY, ST_DONE
  } state_e;

  // entry format: {valid, weight}
  logic [WB:0] edge_mem [DEPTH];
  logic [WB:0] dist_mem [DEPTH];

  state_e             state_q;
  logic [AW:0]        init_q;
  logic [VCOUNT_W-1:0] vcount_q;
  logic [CW-1:0]      i_q, j_q, k_q;
  logic               ph_q;
  logic [VW-1:0]      a_q;
  logic [WB:0]        dik_q;
  logic [WB:0]        e_rd_q, d_rda_q, d_rdb_q;
  out_item_t          res_q, out_q;
  logic               out_valid_q;

  logic               e_we, e_re, d_we, d_rea, d_reb;
  logic [AW-1:0]      e_wa, e_ra, d_wa, d_raa, d_rab;
  logic [WB:0]        e_wd, d_wd;

  logic [CMP_W-1:0]   n_w;
  logic [CW-1:0]      n, n_m1;
  logic               in_fire, a_ok, b_ok;
  logic [VW-1:0]      in_a, in_b;
  logic signed [XW-1:0] w_in_x, w_q_x;
  logic [WB-1:0]      w_in_sat;
  logic [FIELD_W-1:0] q_dist;
  logic signed [WB:0] sum_full;
  logic signed [WB-1:0] sum_sat;
  logic               relax;
  logic               i_last, j_last, k_last;

  assign n_w  = (CMP_W'(vcount_q) > CMP_W'(MAX_VERTICES)) ? CMP_W'(MAX_VERTICES)
                                                           : CMP_W'(vcount_q);
  assign n    = CW'(n_w);
  assign n_m1 = n - CW'(1);
  assign i_last = (i_q == n_m1);
  assign j_last = (j_q == n_m1);
  assign k_last = (k_q == n_m1);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign a_ok = CMP_W'(in_data_i.vertex_a) < n_w;
  assign b_ok = CMP_W'(in_data_i.vertex_b) < n_w;
  assign in_a = in_data_i.vertex_a[VW-1:0];
  assign in_b = in_data_i.vertex_b[VW-1:0];

  // edge weight saturated into the stored width
  assign w_in_x   = XW'(in_data_i.edge_weight);
  assign w_in_sat = (w_in_x > WMAX_X) ? WMAX_X[WB-1:0] :
                    (w_in_x < WMIN_X) ? WMIN_X[WB-1:0] : w_in_x[WB-1:0];

  // stored distance saturated into the result field
  assign w_q_x  = XW'($signed(d_rda_q[WB-1:0]));
  assign q_dist = (w_q_x > OMAX_X) ? OMAX_X[FIELD_W-1:0] :
                  (w_q_x < OMIN_X) ? OMIN_X[FIELD_W-1:0] : w_q_x[FIELD_W-1:0];

  // d_rda_q holds d[k][j], d_rdb_q holds d[i][j]
  assign sum_full = {dik_q[WB-1], dik_q[WB-1:0]} + {d_rda_q[WB-1], d_rda_q[WB-1:0]};
  assign sum_sat  = (sum_full[WB] != sum_full[WB-1])
                    ? (sum_full[WB] ? WMIN_X[WB-1:0] : WMAX_X[WB-1:0])
                    : sum_full[WB-1:0];
  assign relax = d_rda_q[WB] && (!d_rdb_q[WB] || (sum_sat < $signed(d_rdb_q[WB-1:0])));

  always_comb begin
    e_we = 1'b0; e_wa = '0; e_wd = '0;
    e_re = 1'b0; e_ra = '0;
    d_we = 1'b0; d_wa = '0; d_wd = '0;
    d_rea = 1'b0; d_raa = '0;
    d_reb = 1'b0; d_rab = '0;
    case (state_q)
      ST_INIT: begin
        e_we = 1'b1;
        e_wa = init_q[AW-1:0];
        d_we = 1'b1;
        d_wa = init_q[AW-1:0];
        d_wd = {(init_q[AW-1:VW] == init_q[VW-1:0]), {WB{1'b0}}};
      end
      ST_IDLE: begin
        if (in_fire && mode_e'(in_data_i.mode) == MODE_WRITE && a_ok && b_ok) begin
          e_we = 1'b1;
          e_wa = {in_a, in_b};
          e_wd = in_data_i.edge_present ? {1'b1, w_in_sat} : '0;
        end
        if (in_fire && mode_e'(in_data_i.mode) == MODE_QUERY) begin
          d_rea = 1'b1;
          d_raa = {in_a, in_b};
        end
      end
      ST_CLR: begin
        e_we = 1'b1;
        e_wa = ph_q ? {i_q[VW-1:0], a_q} : {a_q, i_q[VW-1:0]};
      end
      ST_CP_RD: begin
        e_re = 1'b1;
        e_ra = {i_q[VW-1:0], j_q[VW-1:0]};
      end
      ST_CP_WR: begin
        d_we = 1'b1;
        d_wa = {i_q[VW-1:0], j_q[VW-1:0]};
        d_wd = (i_q == j_q) ? {1'b1, {WB{1'b0}}} : e_rd_q;
      end
      ST_FW_IK: begin
        d_rea = 1'b1;
        d_raa = {i_q[VW-1:0], k_q[VW-1:0]};
      end
      ST_FW_RD: begin
        d_rea = 1'b1;
        d_raa = {k_q[VW-1:0], j_q[VW-1:0]};
        d_reb = 1'b1;
        d_rab = {i_q[VW-1:0], j_q[VW-1:0]};
      end
      ST_FW_WR: begin
        d_we = relax;
        d_wa = {i_q[VW-1:0], j_q[VW-1:0]};
        d_wd = {1'b1, sum_sat};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    if (e_re) e_rd_q <= edge_mem[e_ra];
  end

  always_ff @(posedge clk_i) begin
    if (d_we)  dist_mem[d_wa] <= d_wd;
    if (d_rea) d_rda_q <= dist_mem[d_raa];
    if (d_reb) d_rdb_q <= dist_mem[d_rab];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vcount_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == (AW+1)'(DEPTH - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            a_q   <= in_a;
            i_q   <= '0;
            j_q   <= '0;
            k_q   <= '0;
            ph_q  <= 1'b0;
            case (mode_e'(in_data_i.mode))
              MODE_CLEAR: begin
                res_q   <= {{FIELD_W{1'b0}}, 1'b0, a_ok};
                state_q <= a_ok ? ST_CLR : ST_DONE;
              end
              MODE_WRITE: begin
                res_q   <= {{FIELD_W{1'b0}}, 1'b0, a_ok && b_ok};
                state_q <= ST_DONE;
              end
              MODE_RECOMP: begin
                res_q   <= {{FIELD_W{1'b0}}, 1'b0, 1'b1};
                state_q <= (n == '0) ? ST_DONE : ST_CP_RD;
              end
              MODE_QUERY: begin
                res_q   <= {{FIELD_W{1'b0}}, 1'b0, a_ok && b_ok};
                state_q <= (a_ok && b_ok) ? ST_QUERY : ST_DONE;
              end
              default: begin
                res_q   <= '0;
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_CLR: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            i_q <= i_q + 1'b1;
            if (i_last) state_q <= ST_DONE;
          end
        end
        ST_CP_RD: state_q <= ST_CP_WR;
        ST_CP_WR: begin
          if (!j_last) begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_CP_RD;
          end else begin
            j_q <= '0;
            if (!i_last) begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_CP_RD;
            end else begin
              i_q     <= '0;
              state_q <= ST_FW_IK;
            end
          end
        end
        ST_FW_IK: state_q <= ST_FW_IKW;
        ST_FW_IKW: begin
          dik_q <= d_rda_q;
          j_q   <= '0;
          if (d_rda_q[WB]) begin
            state_q <= ST_FW_RD;
          end else if (!i_last) begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_FW_IK;
          end else begin
            i_q     <= '0;
            k_q     <= k_q + 1'b1;
            state_q <= k_last ? ST_DONE : ST_FW_IK;
          end
        end
        ST_FW_RD: state_q <= ST_FW_WR;
        ST_FW_WR: begin
          // d[i][k] itself relaxed when j reaches k, keep the cached copy current
          if (relax && j_q == k_q) dik_q <= {1'b1, sum_sat};
          if (!j_last) begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_FW_RD;
          end else begin
            j_q <= '0;
            if (!i_last) begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_FW_IK;
            end else begin
              i_q     <= '0;
              k_q     <= k_q + 1'b1;
              state_q <= k_last ? ST_DONE : ST_FW_IK;
            end
          end
        end
        ST_QUERY: begin
          res_q   <= {(d_rda_q[WB] ? q_dist : {FIELD_W{1'b0}}), d_rda_q[WB],
                      res_q.in_range};
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> design/spath_chk.sv
// port-level checks of the all-pairs shortest path block, bound to its top level
// depends on spath_pkg
`default_nettype none

module spath_chk
  import spath_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o,
  input wire logic [VCOUNT_W-1:0] cfg_data_i,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire in_item_t            in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire out_item_t           out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one transaction at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reachable |-> out_data_o.distance == '0)
    else $error("unreachable result with nonzero distance");

  a_reach_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reachable |-> out_data_o.in_range)
    else $error("reachable result out of range");

endmodule

bind all_pairs_shortest_path spath_chk u_spath_chk (.*);

`default_nettype wire
